// ===== sv/bmp_pkg.sv =====
package bmp_pkg;

  localparam int unsigned HEADER_BYTES = 54;
  localparam logic [5:0]  HDR_LAST     = 6'(HEADER_BYTES - 1);

  localparam logic [5:0] OFS_OFFSET = 6'h0A;
  localparam logic [5:0] OFS_WIDTH  = 6'h12;
  localparam logic [5:0] OFS_HEIGHT = 6'h16;
  localparam logic [5:0] OFS_DEPTH  = 6'h1C;
  localparam logic [5:0] OFS_COMP   = 6'h1E;

  localparam logic [15:0] SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24  = 16'd24;
  localparam logic [15:0] DEPTH_32  = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } bmp_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIGNATURE   = 3'd1,
    ERR_COMPRESSED  = 3'd2,
    ERR_DIMENSIONS  = 3'd3,
    ERR_DEPTH       = 3'd4,
    ERR_OFFSET      = 3'd5,
    ERR_DATA_SHORT  = 3'd6,
    ERR_HEADER_SHORT = 3'd7
  } bmp_err_t;

  typedef struct packed {
    bmp_kind_t   kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] width;
    logic [14:0] height;
    logic [5:0]  depth;
    bmp_err_t    err;
    logic        last;
  } bmp_res_t;

endpackage

// ===== sv/bmp_decode.sv =====
module bmp_decode #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        file_byte,
  input  logic              end_of_file,
  output logic              res_vld,
  output bmp_pkg::bmp_res_t res
);
  import bmp_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_IDLE   = 5'b10000
  } bmp_phase_t;

  bmp_phase_t       phase_r, phase_nxt;
  logic [31:0]      bp_r, bp_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [15:0]      depth_r, depth_nxt;
  logic             comp_nz_r, comp_nz_nxt;
  logic [15:0]      sig_r, sig_nxt;
  logic [23:0]      pix_r, pix_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [1:0]       pad_r, pad_nxt;

  logic [5:0]  p;
  logic [1:0]  sel;
  logic        width_bad;
  logic        height_bad;
  bmp_err_t    hdr_err;
  logic [31:0] eff_off;
  logic        quad;
  logic        done_px;
  logic        col_end;
  logic        row_end;
  logic        do_clear;

  assign p = bp_r[5:0];

  always_comb begin
    width_bad  = (width_r == '0) || width_r[31] || (width_r > 32'(MAX_DIMENSION));
    height_bad = (height_r == '0) || height_r[31] || (height_r > 32'(MAX_DIMENSION));
    eff_off    = (off_r == '0) ? 32'(HEADER_BYTES) : off_r;
    if (sig_r != SIGNATURE) begin
      hdr_err = ERR_SIGNATURE;
    end else if (comp_nz_r) begin
      hdr_err = ERR_COMPRESSED;
    end else if (width_bad || height_bad) begin
      hdr_err = ERR_DIMENSIONS;
    end else if ((depth_r != DEPTH_24) && (depth_r != DEPTH_32)) begin
      hdr_err = ERR_DEPTH;
    end else if ((off_r != '0) && (off_r < 32'(HEADER_BYTES))) begin
      hdr_err = ERR_OFFSET;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  assign quad    = (depth_r == DEPTH_32);
  assign done_px = quad ? (ch_r == 2'd3) : (ch_r == 2'd2);
  assign col_end = ({1'b0, col_r} + 1'b1) >= {1'b0, width_r[DIM_W-1:0]};
  assign row_end = ({1'b0, row_r} + 1'b1) >= {1'b0, height_r[DIM_W-1:0]};

  always_comb begin
    phase_nxt   = phase_r;
    bp_nxt      = bp_r;
    off_nxt     = off_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    depth_nxt   = depth_r;
    comp_nz_nxt = comp_nz_r;
    sig_nxt     = sig_r;
    pix_nxt     = pix_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    ch_nxt      = ch_r;
    pad_nxt     = pad_r;
    do_clear    = 1'b0;
    sel         = '0;
    res_vld     = 1'b0;
    res.kind    = KIND_PIXEL;
    res.red     = '0;
    res.green   = '0;
    res.blue    = '0;
    res.alpha   = '0;
    res.width   = width_r[14:0];
    res.height  = height_r[14:0];
    res.depth   = depth_r[5:0];
    res.err     = ERR_NONE;
    res.last    = 1'b0;

    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          bp_nxt = bp_r + 32'd1;
          if (p < 6'd2) begin
            sel = p[1:0];
            sig_nxt[8*sel[0] +: 8] = file_byte;
          end else if (p >= OFS_OFFSET && p < OFS_OFFSET + 6'd4) begin
            sel = 2'(p - OFS_OFFSET);
            off_nxt[8*sel +: 8] = file_byte;
          end else if (p >= OFS_WIDTH && p < OFS_WIDTH + 6'd4) begin
            sel = 2'(p - OFS_WIDTH);
            width_nxt[8*sel +: 8] = file_byte;
          end else if (p >= OFS_HEIGHT && p < OFS_HEIGHT + 6'd4) begin
            sel = 2'(p - OFS_HEIGHT);
            height_nxt[8*sel +: 8] = file_byte;
          end else if (p >= OFS_DEPTH && p < OFS_DEPTH + 6'd2) begin
            sel = 2'(p - OFS_DEPTH);
            depth_nxt[8*sel[0] +: 8] = file_byte;
          end else if (p >= OFS_COMP && p < OFS_COMP + 6'd4) begin
            comp_nz_nxt = comp_nz_r | (file_byte != '0);
          end
          if (p == HDR_LAST) begin
            res_vld = 1'b1;
            if (hdr_err != ERR_NONE) begin
              res.kind = KIND_ERROR;
              res.err  = hdr_err;
              if (end_of_file) begin
                do_clear = 1'b1;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end else if (end_of_file) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_DATA_SHORT;
              do_clear = 1'b1;
            end else begin
              res.kind  = KIND_HEADER;
              off_nxt   = eff_off;
              pix_nxt   = '0;
              ch_nxt    = '0;
              col_nxt   = '0;
              row_nxt   = '0;
              pad_nxt   = '0;
              phase_nxt = (32'(HEADER_BYTES) >= eff_off) ? PH_PIXEL : PH_SKIP;
            end
          end else if (end_of_file) begin
            res_vld    = 1'b1;
            res.kind   = KIND_ERROR;
            res.err    = ERR_HEADER_SHORT;
            res.width  = '0;
            res.height = '0;
            res.depth  = '0;
            do_clear   = 1'b1;
          end
        end
        PH_SKIP: begin
          bp_nxt = bp_r + 32'd1;
          if (end_of_file) begin
            res_vld  = 1'b1;
            res.kind = KIND_ERROR;
            res.err  = ERR_DATA_SHORT;
            do_clear = 1'b1;
          end else if (bp_nxt >= off_r) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PAD: begin
          if (end_of_file) begin
            res_vld  = 1'b1;
            res.kind = KIND_ERROR;
            res.err  = ERR_DATA_SHORT;
            do_clear = 1'b1;
          end else begin
            pad_nxt = pad_r - 2'd1;
            if (pad_r == 2'd1) begin
              phase_nxt = PH_PIXEL;
            end
          end
        end
        PH_PIXEL: begin
          if (ch_r != 2'd3) begin
            pix_nxt[8*ch_r +: 8] = file_byte;
          end
          if (!done_px) begin
            ch_nxt = ch_r + 2'd1;
            if (end_of_file) begin
              res_vld  = 1'b1;
              res.kind = KIND_ERROR;
              res.err  = ERR_DATA_SHORT;
              do_clear = 1'b1;
            end
          end else begin
            ch_nxt  = '0;
            res_vld = 1'b1;
            if (!(col_end && row_end) && end_of_file) begin
              res.kind = KIND_ERROR;
              res.err  = ERR_DATA_SHORT;
              do_clear = 1'b1;
            end else begin
              res.kind  = KIND_PIXEL;
              res.red   = (ch_r == 2'd2) ? file_byte : pix_r[23:16];
              res.green = pix_r[15:8];
              res.blue  = pix_r[7:0];
              res.alpha = quad ? file_byte : ALPHA_OPAQUE;
              if (col_end && row_end) begin
                res.last = 1'b1;
                if (end_of_file) begin
                  do_clear = 1'b1;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end else if (col_end) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
                if (!quad && (width_r[1:0] != 2'd0)) begin
                  pad_nxt   = width_r[1:0];
                  phase_nxt = PH_PAD;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
          end
        end
        PH_IDLE: begin
          if (end_of_file) begin
            do_clear = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end

    if (do_clear) begin
      phase_nxt   = PH_HEADER;
      bp_nxt      = '0;
      off_nxt     = '0;
      width_nxt   = '0;
      height_nxt  = '0;
      depth_nxt   = '0;
      comp_nz_nxt = 1'b0;
      sig_nxt     = '0;
      pix_nxt     = '0;
      col_nxt     = '0;
      row_nxt     = '0;
      ch_nxt      = '0;
      pad_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      bp_r      <= '0;
      off_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      depth_r   <= '0;
      comp_nz_r <= 1'b0;
      sig_r     <= '0;
      pix_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      ch_r      <= '0;
      pad_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bp_r      <= bp_nxt;
      off_r     <= off_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      depth_r   <= depth_nxt;
      comp_nz_r <= comp_nz_nxt;
      sig_r     <= sig_nxt;
      pix_r     <= pix_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      ch_r      <= ch_nxt;
      pad_r     <= pad_nxt;
    end
  end

endmodule

// ===== sv/bmp_out_fifo.sv =====
module bmp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bmp_pkg::bmp_res_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output bmp_pkg::bmp_res_t out_data
);
  import bmp_pkg::*;

  bmp_res_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room      = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/bmp_stream_to_rgba_unit.sv =====
// BMP byte stream to RGBA pixel decoder for uncompressed 24- and 32-bit files.
// The input channel carries one file byte per beat, with in_end_of_file set on
// the final byte of a file. The result channel carries at most one result per
// input beat: a header acceptance, an error with its code, or one RGBA pixel
// with out_last_pixel marking the final pixel of the image.
// Each byte is held in an input register, decoded by the header and pixel
// logic once the output queue has room, and written into a two-entry output
// queue, from which the result is offered to the receiver. One byte is taken
// per cycle for as long as the receiver keeps up.
// When the receiver stalls, the output queue absorbs up to two results and
// in_ready then drops until a result is taken; nothing is lost or repeated.
// Synchronous active-low reset empties the input register and the queue and
// returns the decoder to waiting for the first byte of a header.
module bmp_stream_to_rgba_unit #(
  parameter int unsigned MAX_DIMENSION = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [14:0] out_image_width,
  output logic [14:0] out_image_height,
  output logic [5:0]  out_bits_per_pixel,
  output logic [2:0]  out_error_code,
  output logic        out_last_pixel
);
  import bmp_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       eof_r;
  logic       fire;
  logic       room;
  logic       res_vld;
  bmp_res_t   res;
  bmp_res_t   out_data;

  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt = in_valid ? 1'b1 : (in_vld_r && !fire);
    if (!in_ready) begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_file_byte;
      eof_r  <= in_end_of_file;
    end
  end

  bmp_decode #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .file_byte   (byte_r),
    .end_of_file (eof_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  bmp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && res_vld),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_result_kind    = out_data.kind;
  assign out_red            = out_data.red;
  assign out_green          = out_data.green;
  assign out_blue           = out_data.blue;
  assign out_alpha          = out_data.alpha;
  assign out_image_width    = out_data.width;
  assign out_image_height   = out_data.height;
  assign out_bits_per_pixel = out_data.depth;
  assign out_error_code     = out_data.err;
  assign out_last_pixel     = out_data.last;

endmodule
